// ----- src/opdc_pkg.sv -----
// Package for the one-pedal drive command block.
// Holds state codes, datapath widths and the controller/datapath command types.
// No dependencies.
package opdc_pkg;

	// Drive state encoding shared by the input and output channels.
	localparam logic [2:0] ST_NEUTRAL = 3'd0;
	localparam logic [2:0] ST_DRIVE   = 3'd1;
	localparam logic [2:0] ST_REVERSE = 3'd2;
	localparam logic [2:0] ST_CRUISE  = 3'd3;
	localparam logic [2:0] ST_BRAKE   = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
	localparam logic [2:0] REG_COAST_SCALE = 3'd1;
	localparam logic [2:0] REG_COAST_CAP   = 3'd2;
	localparam logic [2:0] REG_CRUISE_LIM  = 3'd3;
	localparam logic [2:0] REG_SPEED_RPM   = 3'd4;
	localparam logic [2:0] REG_TORQUE_VEL  = 3'd5;
	localparam logic [2:0] REG_HOLD_FORCE  = 3'd6;
	localparam logic [2:0] REG_DEAD_BAND   = 3'd7;

	localparam int CFG_W   = 31;
	localparam int CFG_IDX_W = 3;

	// Signed width of threshold, difference and divisor arithmetic.
	localparam int DW = 27;

	// Q0.16 current below which the setpoint is forced to zero (0.05).
	localparam logic [15:0] CURRENT_FLOOR = 16'd3277;
	// 1.0 in Q0.16.
	localparam logic signed [DW-1:0] ONE_Q16 = 27'sd65536;

	typedef enum logic [1:0] {
		CUR_ZERO,
		CUR_SAT,
		CUR_QUO
	} cur_sel_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic thr;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
	} dp_sts_t;

endpackage

// ----- src/opdc_ctrl.sv -----
// Controller state machine for the one-pedal drive command block.
// Sequences the datapath and owns the channel handshakes. Uses opdc_pkg.
module opdc_ctrl #(
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              precharge_done,
	output logic              out_valid,
	input  logic              out_stall,
	output opdc_pkg::dp_cmd_t cmd,
	input  opdc_pkg::dp_sts_t sts
);

	localparam int CW = $clog2(FRACTION_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_THR,
		S_DIV,
		S_FIN
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          in_xfer;
	logic          can_finish;

	assign in_stall   = (state_q != S_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign can_finish = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_xfer && precharge_done;
		cmd.prep     = (state_q == S_PREP);
		cmd.thr      = (state_q == S_THR);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = can_finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new command replaces the one that leaves at the same edge.
			if (can_finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					// A tick without precharge is taken and dropped.
					if (in_xfer && precharge_done) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_THR;
				end
				S_THR: begin
					cnt_q   <= '0;
					state_q <= sts.need_div ? S_DIV : S_FIN;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(FRACTION_BITS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (can_finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/opdc_dp.sv -----
// Datapath for the one-pedal drive command block: configuration registers,
// threshold arithmetic, serial divider, held targets and output register. Uses opdc_pkg.
module opdc_dp #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [opdc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [opdc_pkg::CFG_W-1:0]        cfg_data,
	input  logic [15:0]                       throttle,
	input  logic                              brake_pressed,
	input  logic [2:0]                        requested_state,
	input  logic [7:0]                        target_speed,
	input  logic [6:0]                        regen_allowed,
	input  logic                              cruise_enabled,
	input  logic signed [15:0]                speed_left,
	input  logic signed [15:0]                speed_right,
	input  opdc_pkg::dp_cmd_t                 cmd,
	output opdc_pkg::dp_sts_t                 sts,
	output logic signed [31:0]                velocity_setpoint,
	output logic [15:0]                       current_setpoint,
	output logic [2:0]                        applied_state
);

	localparam int DW = opdc_pkg::DW;

	// Configuration registers.
	logic [14:0] max_speed_q;
	logic [15:0] coast_scale_q;
	logic [15:0] coast_cap_q;
	logic [15:0] cruise_lim_q;
	logic [23:0] speed_rpm_q;
	logic [30:0] torque_vel_q;
	logic [15:0] hold_force_q;
	logic [15:0] dead_band_q;

	// Held targets.
	logic [31:0] held_vel_q;
	logic [15:0] held_cur_q;

	// Latched tick.
	logic [15:0]        thr_q;
	logic               brake_q;
	logic [2:0]         req_q;
	logic [7:0]         tspeed_q;
	logic               regen_q;
	logic               cruise_q;
	logic signed [16:0] sum_q;

	// First stage: overridden state and the two products.
	logic [2:0]         st_s1;
	logic signed [33:0] prod_s1;
	logic               cap_s1;
	logic [31:0]        cruise_v_s1;

	// Second stage: final state, current source and divider operands.
	logic [2:0]              st_s2;
	opdc_pkg::cur_sel_t      sel_s2;
	logic [DW-1:0]           rem_q;
	logic [DW-1:0]           den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [15:0]             quo16;

	logic [2:0]              st_ovr;
	logic signed [DW-1:0]    t_c;
	logic signed [DW-1:0]    diff_c;
	logic signed [DW-1:0]    den_c;
	logic signed [DW-1:0]    thr_c;
	logic signed [DW-1:0]    db_c;
	logic                    in_band_c;
	logic                    below_c;
	logic                    sat_c;
	logic                    pedal_st_c;
	logic [DW-1:0]           r2_c;
	logic                    ge_c;
	logic [31:0]             vel_n;
	logic [15:0]             cur_n;
	logic [15:0]             cur_src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= 15'd8960;
			coast_scale_q <= 16'd655;
			coast_cap_q   <= 16'd22938;
			cruise_lim_q  <= 16'd3277;
			speed_rpm_q   <= 24'd65536;
			torque_vel_q  <= 31'd1310720000;
			hold_force_q  <= 16'd32768;
			dead_band_q   <= 16'd3277;
		end else if (cfg_we) begin
			case (cfg_index)
				opdc_pkg::REG_MAX_SPEED:   max_speed_q   <= cfg_data[14:0];
				opdc_pkg::REG_COAST_SCALE: coast_scale_q <= cfg_data[15:0];
				opdc_pkg::REG_COAST_CAP:   coast_cap_q   <= cfg_data[15:0];
				opdc_pkg::REG_CRUISE_LIM:  cruise_lim_q  <= cfg_data[15:0];
				opdc_pkg::REG_SPEED_RPM:   speed_rpm_q   <= cfg_data[23:0];
				opdc_pkg::REG_TORQUE_VEL:  torque_vel_q  <= cfg_data[30:0];
				opdc_pkg::REG_HOLD_FORCE:  hold_force_q  <= cfg_data[15:0];
				opdc_pkg::REG_DEAD_BAND:   dead_band_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Cruise override, then brake / zero-throttle override.
	always_comb begin
		st_ovr = req_q;
		if (st_ovr == opdc_pkg::ST_DRIVE && cruise_q && thr_q <= cruise_lim_q) begin
			st_ovr = opdc_pkg::ST_CRUISE;
		end
		if (brake_q || (thr_q == 16'd0 && st_ovr != opdc_pkg::ST_CRUISE)) begin
			st_ovr = regen_q ? opdc_pkg::ST_BRAKE : opdc_pkg::ST_NEUTRAL;
		end
	end

	// Threshold from car speed; an arithmetic shift floors negative products.
	always_comb begin
		t_c       = cap_s1 ? $signed({11'd0, coast_cap_q}) : DW'(prod_s1 >>> 9);
		thr_c     = $signed({11'd0, thr_q});
		db_c      = $signed({11'd0, dead_band_q});
		diff_c    = thr_c - t_c;
		den_c     = opdc_pkg::ONE_Q16 - t_c;
		in_band_c = (diff_c <= db_c) && (-diff_c <= db_c);
		below_c   = diff_c < 0;
		sat_c     = (den_c <= 0) || (diff_c >= den_c);
		pedal_st_c = (st_s1 == opdc_pkg::ST_DRIVE) || (st_s1 == opdc_pkg::ST_REVERSE);
	end

	assign sts.need_div = pedal_st_c && !in_band_c && !below_c && !sat_c;

	assign r2_c = {rem_q[DW-2:0], 1'b0};
	assign ge_c = r2_c >= den_q;

	// Quotient has FRACTION_BITS fraction bits; bring it to Q0.16.
	generate
		if (FRACTION_BITS >= 16) begin : g_quo_trunc
			assign quo16 = quo_q[FRACTION_BITS-1 -: 16];
		end else begin : g_quo_wide
			assign quo16 = {quo_q, {(16 - FRACTION_BITS){1'b0}}};
		end
	endgenerate

	always_comb begin
		case (sel_s2)
			opdc_pkg::CUR_SAT: cur_src = 16'hFFFF;
			opdc_pkg::CUR_QUO: cur_src = quo16;
			default:           cur_src = 16'd0;
		endcase
	end

	always_comb begin
		vel_n = held_vel_q;
		cur_n = held_cur_q;
		case (st_s2)
			opdc_pkg::ST_DRIVE: begin
				cur_n = cur_src;
				vel_n = {1'b0, torque_vel_q};
			end
			opdc_pkg::ST_REVERSE: begin
				cur_n = cur_src;
				vel_n = 32'd0 - {1'b0, torque_vel_q};
			end
			opdc_pkg::ST_CRUISE: begin
				cur_n = hold_force_q;
				vel_n = cruise_v_s1[31] ? 32'h7FFF_FFFF : cruise_v_s1;
			end
			opdc_pkg::ST_BRAKE: begin
				cur_n = hold_force_q;
				vel_n = 32'd0;
			end
			opdc_pkg::ST_NEUTRAL: begin
				cur_n = 16'd0;
				vel_n = 32'd0;
			end
			default: ;
		endcase
		if (cur_n < opdc_pkg::CURRENT_FLOOR) begin
			cur_n = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vel_q <= 32'd0;
			held_cur_q <= 16'd0;
		end else if (cmd.finish) begin
			held_vel_q <= vel_n;
			held_cur_q <= cur_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			thr_q    <= throttle;
			brake_q  <= brake_pressed;
			req_q    <= requested_state;
			tspeed_q <= target_speed;
			regen_q  <= (regen_allowed != 7'd0);
			cruise_q <= cruise_enabled;
			sum_q    <= $signed({speed_left[15], speed_left})
				+ $signed({speed_right[15], speed_right});
		end
		if (cmd.prep) begin
			st_s1       <= st_ovr;
			prod_s1     <= sum_q * $signed({1'b0, coast_scale_q});
			cap_s1      <= $signed({sum_q[16], sum_q}) > $signed({2'b00, max_speed_q, 1'b0});
			cruise_v_s1 <= {24'd0, tspeed_q} * {8'd0, speed_rpm_q};
		end
		if (cmd.thr) begin
			st_s2  <= st_s1;
			sel_s2 <= opdc_pkg::CUR_ZERO;
			rem_q  <= diff_c;
			den_q  <= den_c;
			quo_q  <= '0;
			if (pedal_st_c && !in_band_c) begin
				if (below_c) begin
					st_s2 <= opdc_pkg::ST_BRAKE;
				end else if (sat_c) begin
					sel_s2 <= opdc_pkg::CUR_SAT;
				end else begin
					sel_s2 <= opdc_pkg::CUR_QUO;
				end
			end
		end
		if (cmd.div_step) begin
			rem_q <= ge_c ? (r2_c - den_q) : r2_c;
			quo_q <= {quo_q[FRACTION_BITS-2:0], ge_c};
		end
		if (cmd.finish) begin
			velocity_setpoint <= $signed(vel_n);
			current_setpoint  <= cur_n;
			applied_state     <= st_s2;
		end
	end

endmodule

// ----- src/one_pedal_drive_command.sv -----
// Top level of the one-pedal drive command block.
// Instantiates opdc_ctrl and opdc_dp; uses opdc_pkg.
//
// Usage: one tick of driver inputs enters on the input channel (in_valid /
// in_stall) and yields one drive command on the output channel (out_valid /
// out_stall). A tick with precharge_done low is taken and dropped: no command
// comes out and the held targets stay as they are.
// Sequence: a transfer in is followed by a step of state overrides and
// multiplies (PREP), a step of threshold and band decision (THR), the
// restoring divider for FRACTION_BITS quotient bits when the pedal maps to a
// fraction (DIV), and a step to update the held targets and load the output
// register (FIN). The controller then returns to idle, where the next tick
// is taken. The divider loop sets the rate; one tick is in flight at a time.
// The output register keeps a command while out_stall is high; the block still
// takes the next tick and only holds its final step until the register frees.
// Configuration is written through cfg_we / cfg_index / cfg_data, one register
// a cycle; the user must write it only while no tick is in flight, as the
// block itself does not enforce this.
// Reset (arst_n low) restores the configuration registers to their defaults
// and clears the held velocity and current to zero; no command is pending afterwards.
module one_pedal_drive_command #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [opdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [opdc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    throttle,
	input  logic                           brake_pressed,
	input  logic [2:0]                     requested_state,
	input  logic [7:0]                     target_speed,
	input  logic [6:0]                     regen_allowed,
	input  logic                           cruise_enabled,
	input  logic signed [15:0]             speed_left,
	input  logic signed [15:0]             speed_right,
	input  logic                           precharge_done,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             velocity_setpoint,
	output logic [15:0]                    current_setpoint,
	output logic [2:0]                     applied_state
);

	// Commands from the sequencer and status back from the datapath.
	opdc_pkg::dp_cmd_t cmd;
	opdc_pkg::dp_sts_t sts;

	opdc_ctrl #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.precharge_done (precharge_done),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.sts            (sts)
	);

	opdc_dp #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.throttle          (throttle),
		.brake_pressed     (brake_pressed),
		.requested_state   (requested_state),
		.target_speed      (target_speed),
		.regen_allowed     (regen_allowed),
		.cruise_enabled    (cruise_enabled),
		.speed_left        (speed_left),
		.speed_right       (speed_right),
		.cmd               (cmd),
		.sts               (sts),
		.velocity_setpoint (velocity_setpoint),
		.current_setpoint  (current_setpoint),
		.applied_state     (applied_state)
	);

endmodule

// ----- tb/tb_one_pedal_drive_command.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for one_pedal_drive_command: random and directed ticks.
// Depends on opdc_pkg and the one_pedal_drive_command RTL only.
module tb_one_pedal_drive_command;

	// The divider resolution the block is built with; the predictor uses it as well.
	localparam int FRACTION_BITS = 16;
	// Requested states above BRAKE have no meaning; the block re-sends its held targets.
	localparam logic [2:0] ST_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] ST_UNKNOWN_LAST  = 3'd7;
	// A drain of twice the longest tick time lets any dropped tick finish.
	localparam int DRAIN_CYCLES = 2 * (FRACTION_BITS + 4);
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 1000000;

	// One tick of driver inputs, as presented on the input channel.
	typedef struct packed {
		logic [15:0] throttle;
		logic        brake_pressed;
		logic [2:0]  requested_state;
		logic [7:0]  target_speed;
		logic [6:0]  regen_allowed;
		logic        cruise_enabled;
		logic [15:0] speed_left;
		logic [15:0] speed_right;
		logic        precharge_done;
	} tick_t;

	// One drive command, as delivered on the output channel.
	typedef struct packed {
		logic [31:0] velocity;
		logic [15:0] current;
		logic [2:0]  state;
	} command_t;

	typedef longint reg_set_t [8];

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [opdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [opdc_pkg::CFG_W-1:0]     cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        throttle = '0;
	logic               brake_pressed = 1'b0;
	logic [2:0]         requested_state = opdc_pkg::ST_NEUTRAL;
	logic [7:0]         target_speed = '0;
	logic [6:0]         regen_allowed = '0;
	logic               cruise_enabled = 1'b0;
	logic signed [15:0] speed_left = '0;
	logic signed [15:0] speed_right = '0;
	logic               precharge_done = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] velocity_setpoint;
	logic [15:0]        current_setpoint;
	logic [2:0]         applied_state;

	// Register values as they come out of reset, in register index order.
	reg_set_t reset_settings = '{8960, 655, 22938, 3277, 65536, 1310720000, 32768, 3277};
	// The predictor's copy of the registers and of the held targets.
	reg_set_t    cfg_copy;
	logic [31:0] held_velocity = '0;
	logic [15:0] held_current = '0;

	command_t expected_commands [$];
	int       failures = 0;
	int       commands_checked = 0;
	int       ticks_sent = 0;
	int       settings_loaded = 0;
	int       burst_left = 0;
	int       cycle_count = 0;
	// The stimulus asks for a long output hold by bumping hold_requests;
	// the receiver counts the hold out itself and then catches up holds_done.
	int       hold_requests = 0;
	int       holds_done = 0;

	one_pedal_drive_command #(
		.FRACTION_BITS(FRACTION_BITS)
	) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("one_pedal_drive_command: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic longint reg_limit(input logic [2:0] idx);
		case (idx)
			opdc_pkg::REG_MAX_SPEED:  return 32767;
			opdc_pkg::REG_SPEED_RPM:  return 16777215;
			opdc_pkg::REG_TORQUE_VEL: return 2147483647;
			default:                  return 65535;
		endcase
	endfunction

	// Coasting threshold in signed Q0.16 from the sum of both wheel speeds (Q8.8 each).
	// The product carries 8 + 16 fraction bits and the sum is twice the car speed,
	// so a right shift by 9 gives Q0.16; the arithmetic shift rounds toward minus
	// infinity, which is what the block does for reversing speeds as well.
	function automatic longint coast_threshold(input longint speed_sum);
		if (speed_sum > 2 * cfg_copy[opdc_pkg::REG_MAX_SPEED])
			return cfg_copy[opdc_pkg::REG_COAST_CAP];
		return (speed_sum * cfg_copy[opdc_pkg::REG_COAST_SCALE]) >>> 9;
	endfunction

	// Pedal travel above the threshold as a fraction of the travel left, truncated
	// to FRACTION_BITS and then brought to Q0.16; 1.0 or more saturates.
	function automatic logic [15:0] pedal_fraction(input longint num, input longint den);
		longint q;
		if (den <= 0 || num >= den)
			return 16'hFFFF;
		q = (num << FRACTION_BITS) / den;
		if (FRACTION_BITS >= 16)
			q = q >> (FRACTION_BITS - 16);
		else
			q = q << (16 - FRACTION_BITS);
		return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
	endfunction

	// Works out the command for one accepted tick and updates the held targets.
	// Returns 0 when the tick produces no command (precharge not finished).
	function automatic bit drive_command(input tick_t t, output command_t c);
		logic [2:0]  st;
		logic [15:0] cur;
		longint      pedal, thr_point, band, rpm;
		c = '0;
		if (!t.precharge_done)
			return 0;
		st = t.requested_state;
		pedal = longint'(t.throttle);
		cur = '0;
		// Cruise only takes over from drive, and only with the pedal nearly released.
		if (st == opdc_pkg::ST_DRIVE && t.cruise_enabled
			&& pedal <= cfg_copy[opdc_pkg::REG_CRUISE_LIM])
			st = opdc_pkg::ST_CRUISE;
		// The brake pedal always wins; a released pedal wins unless cruising.
		if (t.brake_pressed || (pedal == 0 && st != opdc_pkg::ST_CRUISE))
			st = (t.regen_allowed != 0) ? opdc_pkg::ST_BRAKE : opdc_pkg::ST_NEUTRAL;
		if (st == opdc_pkg::ST_DRIVE || st == opdc_pkg::ST_REVERSE) begin
			thr_point = coast_threshold(longint'($signed(t.speed_left))
				+ longint'($signed(t.speed_right)));
			band = cfg_copy[opdc_pkg::REG_DEAD_BAND];
			if (pedal - thr_point <= band && thr_point - pedal <= band)
				cur = '0;
			else if (pedal >= thr_point)
				cur = pedal_fraction(pedal - thr_point, 65536 - thr_point);
			else
				st = opdc_pkg::ST_BRAKE;
		end
		case (st)
			opdc_pkg::ST_DRIVE: begin
				held_current = cur;
				held_velocity = 32'(cfg_copy[opdc_pkg::REG_TORQUE_VEL]);
			end
			opdc_pkg::ST_REVERSE: begin
				held_current = cur;
				held_velocity = 32'(-cfg_copy[opdc_pkg::REG_TORQUE_VEL]);
			end
			opdc_pkg::ST_CRUISE: begin
				rpm = longint'(t.target_speed) * cfg_copy[opdc_pkg::REG_SPEED_RPM];
				held_current = 16'(cfg_copy[opdc_pkg::REG_HOLD_FORCE]);
				held_velocity = (rpm > 64'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(rpm);
			end
			opdc_pkg::ST_BRAKE: begin
				held_current = 16'(cfg_copy[opdc_pkg::REG_HOLD_FORCE]);
				held_velocity = '0;
			end
			opdc_pkg::ST_NEUTRAL: begin
				held_current = '0;
				held_velocity = '0;
			end
			default: ;
		endcase
		// Small currents are cleared in the held state itself, also on a re-send.
		if (held_current < opdc_pkg::CURRENT_FLOOR)
			held_current = '0;
		c.velocity = held_velocity;
		c.current = held_current;
		c.state = st;
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic tick_t make_tick(input logic [15:0] thr, input logic brake,
		input logic [2:0] st, input logic [7:0] tspeed, input logic [6:0] regen,
		input logic cruise, input logic [15:0] left, input logic [15:0] right,
		input logic precharge);
		return '{thr, brake, st, tspeed, regen, cruise, left, right, precharge};
	endfunction

	// Random tick aimed at the interesting regions of the current settings:
	// mostly drive and reverse, speeds around the one-pedal speed limit, and
	// pedal positions on both sides of the coasting band and the cruise limit.
	function automatic tick_t random_tick();
		tick_t  t;
		int     pick, base;
		longint pos, band;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			t.requested_state = opdc_pkg::ST_DRIVE;
		else if (pick < 55)
			t.requested_state = opdc_pkg::ST_REVERSE;
		else if (pick < 65)
			t.requested_state = opdc_pkg::ST_CRUISE;
		else if (pick < 72)
			t.requested_state = opdc_pkg::ST_BRAKE;
		else if (pick < 80)
			t.requested_state = opdc_pkg::ST_NEUTRAL;
		else
			t.requested_state = 3'($urandom_range(opdc_pkg::ST_NEUTRAL, ST_UNKNOWN_LAST));
		t.brake_pressed = ($urandom_range(0, 9) == 0);
		t.regen_allowed = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(1, 100));
		t.cruise_enabled = 1'($urandom_range(0, 1));
		t.target_speed = 8'($urandom);
		t.precharge_done = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 3))
			0: begin
				t.speed_left = 16'($urandom);
				t.speed_right = 16'($urandom);
			end
			1: begin
				base = $urandom_range(0, int'(cfg_copy[opdc_pkg::REG_MAX_SPEED]));
				t.speed_left = 16'(base);
				t.speed_right = 16'(base + $urandom_range(0, 128) - 64);
			end
			2: begin
				t.speed_left = 16'(-$urandom_range(0, 4000));
				t.speed_right = 16'($urandom_range(0, 3000) - 1500);
			end
			default: begin
				// Car speed right at the point where the threshold switches to its cap.
				t.speed_left = 16'(cfg_copy[opdc_pkg::REG_MAX_SPEED]);
				t.speed_right = 16'(cfg_copy[opdc_pkg::REG_MAX_SPEED]
					+ $urandom_range(0, 1));
			end
		endcase
		band = cfg_copy[opdc_pkg::REG_DEAD_BAND];
		case ($urandom_range(0, 5))
			0: pos = $urandom_range(0, 65535);
			1: pos = 0;
			2: pos = 65535;
			3: pos = cfg_copy[opdc_pkg::REG_CRUISE_LIM] + $urandom_range(0, 2) - 1;
			default: pos = coast_threshold(longint'($signed(t.speed_left))
				+ longint'($signed(t.speed_right)))
				+ longint'($urandom_range(0, 32'(2 * band + 4))) - band - 2;
		endcase
		t.throttle = (pos < 0) ? 16'h0 : (pos > 65535) ? 16'hFFFF : 16'(pos);
		return t;
	endfunction

	function automatic reg_set_t random_settings();
		reg_set_t s;
		for (int i = 0; i <= opdc_pkg::REG_DEAD_BAND; i++) begin
			case ($urandom_range(0, 7))
				0: s[i] = 0;
				1: s[i] = reg_limit(3'(i));
				// Every range is all ones, so a mask gives a uniform value in range.
				default: s[i] = longint'($urandom) & reg_limit(3'(i));
			endcase
		end
		// Most settings keep the threshold and the band well inside 0..1.0,
		// otherwise nearly every pedal position lands in one branch.
		if ($urandom_range(0, 3) != 0) begin
			s[opdc_pkg::REG_COAST_SCALE] = $urandom_range(0, 2000);
			s[opdc_pkg::REG_DEAD_BAND] = $urandom_range(0, 6000);
			s[opdc_pkg::REG_MAX_SPEED] = $urandom_range(0, 16000);
		end
		return s;
	endfunction

	// Offers one tick and waits for its transfer. The sender works in bursts:
	// at the start of a burst it may idle for a while first. Valid stays high
	// from one tick to the next inside a burst.
	task automatic send_tick(input tick_t t);
		command_t c;
		int       gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		throttle <= t.throttle;
		brake_pressed <= t.brake_pressed;
		requested_state <= t.requested_state;
		target_speed <= t.target_speed;
		regen_allowed <= t.regen_allowed;
		cruise_enabled <= t.cruise_enabled;
		speed_left <= t.speed_left;
		speed_right <= t.speed_right;
		precharge_done <= t.precharge_done;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		// Accepted at this edge: predict now, in transfer order.
		if (drive_command(t, c))
			expected_commands.push_back(c);
		ticks_sent++;
	endtask

	// Registers may only change with nothing in flight. A dropped tick leaves no
	// trace in the queue, so after the last command a full tick time is allowed.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_commands.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(input reg_set_t vals);
		wait_idle();
		for (int i = 0; i <= opdc_pkg::REG_DEAD_BAND; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= opdc_pkg::CFG_IDX_W'(i);
			cfg_data <= opdc_pkg::CFG_W'(vals[i]);
			cfg_copy[i] = vals[i] & reg_limit(3'(i));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_tick(random_tick());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Directed ticks under the reset values of the registers. Speeds are Q8.8:
	// 16'd2560 is 10 kph, which puts the threshold at 6550 with the reset scale.
	task automatic test_reset_defaults();
		// Unknown state straight after reset re-sends the cleared held targets.
		send_tick(make_tick(16'd30000, 1'b0, ST_UNKNOWN_LAST, 8'd0, 7'd100, 1'b0, 16'd0,
			16'd0, 1'b1));
		// Full pedal at standstill: threshold 0, largest fraction.
		send_tick(make_tick(16'hFFFF, 1'b0, opdc_pkg::ST_DRIVE, 8'd0, 7'd100, 1'b0,
			16'd0, 16'd0, 1'b1));
		send_tick(make_tick(16'd0, 1'b0, ST_UNKNOWN_FIRST, 8'd0, 7'd0, 1'b0, 16'd0, 16'd0,
			1'b1));
		// No precharge: dropped, and the held targets must not move.
		send_tick(make_tick(16'd20000, 1'b0, opdc_pkg::ST_REVERSE, 8'd10, 7'd5, 1'b0,
			16'd256, 16'd256, 1'b0));
		send_tick(make_tick(16'd40000, 1'b0, opdc_pkg::ST_REVERSE, 8'd0, 7'd1, 1'b0,
			16'd2560, 16'd2560, 1'b1));
		// Pedal right on the threshold: inside the coasting band, current 0.
		send_tick(make_tick(16'd6550, 1'b0, opdc_pkg::ST_DRIVE, 8'd0, 7'd1, 1'b0,
			16'd2560, 16'd2560, 1'b1));
		send_tick(make_tick(16'hFFFF, 1'b1, 3'd6, 8'hFF, 7'd0, 1'b1, 16'd0, 16'd0, 1'b1));
		// Pedal well under the threshold at 30 kph: switches to brake.
		send_tick(make_tick(16'd1000, 1'b0, opdc_pkg::ST_DRIVE, 8'd0, 7'd64, 1'b0,
			16'd7680, 16'd7680, 1'b1));
		// Fastest forward speed: threshold capped.
		send_tick(make_tick(16'hFFFF, 1'b0, opdc_pkg::ST_DRIVE, 8'd0, 7'd64, 1'b0,
			16'h7FFF, 16'h7FFF, 1'b1));
		// Fastest reverse speed: negative threshold.
		send_tick(make_tick(16'd30000, 1'b0, opdc_pkg::ST_REVERSE, 8'd0, 7'd64, 1'b0,
			16'h8000, 16'h8000, 1'b1));
		// Speed sum of -1 kph/256: the threshold rounds down to -2, pedal 2 is coasting.
		send_tick(make_tick(16'd2, 1'b0, opdc_pkg::ST_DRIVE, 8'd0, 7'd64, 1'b0,
			16'h7FFF, 16'h8000, 1'b1));
		// Cruise takes over at the limit and not one step above it.
		send_tick(make_tick(16'd3277, 1'b0, opdc_pkg::ST_DRIVE, 8'hFF, 7'd64, 1'b1,
			16'd0, 16'd0, 1'b1));
		send_tick(make_tick(16'd3278, 1'b0, opdc_pkg::ST_DRIVE, 8'hFF, 7'd64, 1'b1,
			16'd0, 16'd0, 1'b1));
		// Requested cruise keeps cruising with the pedal released.
		send_tick(make_tick(16'd0, 1'b0, opdc_pkg::ST_CRUISE, 8'd0, 7'd0, 1'b0,
			16'd0, 16'd0, 1'b1));
		send_tick(make_tick(16'd500, 1'b1, opdc_pkg::ST_CRUISE, 8'd100, 7'd1, 1'b1,
			16'd0, 16'd0, 1'b1));
		// Brake without regen gives neutral.
		send_tick(make_tick(16'd500, 1'b1, opdc_pkg::ST_DRIVE, 8'd0, 7'd0, 1'b0,
			16'd0, 16'd0, 1'b1));
		// Released pedal in drive, with and without regen.
		send_tick(make_tick(16'd0, 1'b0, opdc_pkg::ST_DRIVE, 8'd0, 7'd100, 1'b0,
			16'd0, 16'd0, 1'b1));
		send_tick(make_tick(16'd0, 1'b0, opdc_pkg::ST_DRIVE, 8'd0, 7'd0, 1'b0,
			16'd0, 16'd0, 1'b1));
		send_tick(make_tick(16'd500, 1'b0, opdc_pkg::ST_NEUTRAL, 8'd0, 7'd100, 1'b0,
			16'd0, 16'd0, 1'b1));
		send_tick(make_tick(16'd500, 1'b0, opdc_pkg::ST_BRAKE, 8'hAA, 7'h55, 1'b1,
			16'h5555, 16'hAAAA, 1'b1));
		send_tick(make_tick(16'd0, 1'b0, ST_UNKNOWN_FIRST, 8'd0, 7'd0, 1'b0, 16'd0, 16'd0,
			1'b1));
	endtask

	// All registers at zero, then all at their largest value.
	task automatic test_register_extremes();
		reg_set_t s;
		for (int i = 0; i <= opdc_pkg::REG_DEAD_BAND; i++)
			s[i] = 0;
		program_registers(s);
		send_random(60);
		for (int i = 0; i <= opdc_pkg::REG_DEAD_BAND; i++)
			s[i] = reg_limit(3'(i));
		program_registers(s);
		send_random(60);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 6; p++) begin
			program_registers(random_settings());
			send_random(80);
		end
	endtask

	// The receiver holds off for a long stretch while ticks keep coming, so the
	// output register stays full and the block has to stall its input.
	task automatic test_output_backpressure();
		hold_requests <= hold_requests + 1;
		send_random(40);
	endtask

	task automatic test_random_ticks();
		program_registers(reset_settings);
		send_random(1200);
	endtask

	// ------------------------------------------------------------------
	// Receiver: stalls on a pattern that changes every so often, including
	// stretches without any stall, plus the long hold on request.
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int mode_left = 0;
	int hold_count = 0;

	always @(posedge clk) begin
		if (holds_done != hold_requests) begin
			out_stall <= 1'b1;
			if (hold_count == LONG_HOLD - 1) begin
				hold_count <= 0;
				holds_done <= holds_done + 1;
			end else begin
				hold_count <= hold_count + 1;
			end
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (cycle_count % 7 < 3);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checker: every command transfer is compared with the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		command_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_commands.size() == 0) begin
				$error("unexpected command: velocity_setpoint %0d current_setpoint %0d %s %0d",
					velocity_setpoint, current_setpoint, "applied_state", applied_state);
				failures++;
			end else begin
				want = expected_commands.pop_front();
				commands_checked++;
				if (velocity_setpoint !== $signed(want.velocity)) begin
					$error("velocity_setpoint: expected %0d, got %0d",
						$signed(want.velocity), velocity_setpoint);
					failures++;
				end
				if (current_setpoint !== want.current) begin
					$error("current_setpoint: expected %0d, got %0d",
						want.current, current_setpoint);
					failures++;
				end
				if (applied_state !== want.state) begin
					$error("applied_state: expected %0d, got %0d", want.state, applied_state);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_copy = reset_settings;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_settings();
		test_output_backpressure();
		test_random_ticks();

		in_valid <= 1'b0;
		for (int n = 0; n < 5000 && expected_commands.size() != 0; n++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_commands.size() != 0)
			$error("%0d predicted commands never arrived", expected_commands.size());

		$display("Sent %0d ticks and checked %0d commands over %0d register settings,",
			ticks_sent, commands_checked, settings_loaded + 1);
		$display("with random sender gaps, receiver stalls and a %0d-cycle output hold.",
			LONG_HOLD);
		if (failures == 0 && expected_commands.size() == 0) begin
			$display("one_pedal_drive_command: match");
		end else begin
			$display("one_pedal_drive_command: mismatch");
		end
		$finish;
	end

endmodule
